// ===== rtl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants for the utf-8 to utf-32 decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 16;
    localparam int CODE_W  = 21;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // lead and continuation byte payload masks
    localparam logic [7:0] ASCII_MASK   = 8'b0111_1111;
    localparam logic [7:0] LEAD2_MASK   = 8'b0001_1111;
    localparam logic [7:0] LEAD3_MASK   = 8'b0000_1111;
    localparam logic [7:0] LEAD4_MASK   = 8'b0000_0111;
    localparam logic [7:0] CONT_MASK    = 8'b0011_1111;
    // continuation tag test
    localparam logic [7:0] CONT_TAG_SEL = 8'b1100_0000;
    localparam logic [7:0] CONT_TAG     = 8'b1000_0000;

    typedef enum logic [1:0] {
        ST_CHAR     = 2'd0,
        ST_TERM     = 2'd1,
        ST_BAD_LEAD = 2'd2,
        ST_BAD_CONT = 2'd3
    } t_status;

    typedef struct packed {
        logic [LIMIT_W-1:0] char_limit;
        logic               start_of_string;
        logic [BYTE_W-1:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        t_status           status;
        logic              last;
    } t_result;

endpackage

// ===== rtl/u8d_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8d_in_reg
// input register stage, holds one accepted byte for the decode stage
// ----------------------------------------------------------------------------
module u8d_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  u8d_pkg::t_in_item  i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output u8d_pkg::t_in_item  o_item
);

    logic              r_valid;
    u8d_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/u8d_core.sv =====
// ----------------------------------------------------------------------------
// u8d_core
// decode state and per-byte logic: sequence tracking, code point assembly,
// character count and string end
// ----------------------------------------------------------------------------
module u8d_core #(
    parameter int COUNT_BITS = u8d_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_advance,
    input  u8d_pkg::t_in_item i_item,
    output logic              o_res_valid,
    output u8d_pkg::t_result  o_res
);

    logic                          r_active;
    logic [1:0]                    r_left;
    logic [u8d_pkg::CODE_W-1:0]    r_part;
    logic [COUNT_BITS-1:0]         r_cnt;
    logic [COUNT_BITS-1:0]         r_lim;

    logic                          n_active;
    logic [1:0]                    n_left;
    logic [u8d_pkg::CODE_W-1:0]    n_part;
    logic [COUNT_BITS-1:0]         n_cnt;
    logic [COUNT_BITS-1:0]         n_lim;

    logic                          act_e;
    logic [1:0]                    left_e;
    logic [u8d_pkg::CODE_W-1:0]    part_e;
    logic [COUNT_BITS-1:0]         cnt_e;
    logic [COUNT_BITS-1:0]         lim_e;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic [u8d_pkg::CODE_W-1:0]    part_sh;
    logic [7:0]                    b;
    logic                          fire;

    assign fire    = i_valid && i_advance;
    assign b       = i_item.data_byte;
    assign cnt_inc = cnt_e + COUNT_BITS'(1);

    always_comb begin
        // a start drops any partial sequence and samples the limit
        if (i_item.start_of_string) begin
            lim_e  = COUNT_BITS'(i_item.char_limit);
            act_e  = (lim_e != '0);
            left_e = 2'd0;
            part_e = '0;
            cnt_e  = '0;
        end else begin
            lim_e  = r_lim;
            act_e  = r_active;
            left_e = r_left;
            part_e = r_part;
            cnt_e  = r_cnt;
        end
        part_sh = {part_e[u8d_pkg::CODE_W-7:0], b[5:0] & u8d_pkg::CONT_MASK[5:0]};

        n_active = act_e;
        n_left   = left_e;
        n_part   = part_e;
        n_cnt    = cnt_e;
        n_lim    = lim_e;

        o_res_valid      = 1'b0;
        o_res.code_point = '0;
        o_res.status     = u8d_pkg::ST_CHAR;
        o_res.last       = 1'b0;

        if (act_e) begin
            if (left_e == 2'd0) begin
                if (b == 8'h00) begin
                    o_res_valid  = 1'b1;
                    o_res.status = u8d_pkg::ST_TERM;
                    o_res.last   = 1'b1;
                    n_active     = 1'b0;
                end else if (b inside {[8'h01:8'h7F]}) begin
                    o_res_valid      = 1'b1;
                    o_res.code_point = u8d_pkg::CODE_W'(b & u8d_pkg::ASCII_MASK);
                    o_res.last       = (cnt_inc == lim_e);
                    n_cnt            = cnt_inc;
                    n_active         = !(cnt_inc == lim_e);
                end else if (b inside {[8'hC0:8'hDF]}) begin
                    n_left = 2'd1;
                    n_part = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD2_MASK);
                end else if (b inside {[8'hE0:8'hEF]}) begin
                    n_left = 2'd2;
                    n_part = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD3_MASK);
                end else if (b inside {[8'hF0:8'hF7]}) begin
                    n_left = 2'd3;
                    n_part = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD4_MASK);
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.status = u8d_pkg::ST_BAD_LEAD;
                    o_res.last   = 1'b1;
                    n_active     = 1'b0;
                end
            end else if ((b & u8d_pkg::CONT_TAG_SEL) != u8d_pkg::CONT_TAG) begin
                o_res_valid  = 1'b1;
                o_res.status = u8d_pkg::ST_BAD_CONT;
                o_res.last   = 1'b1;
                n_active     = 1'b0;
                n_left       = 2'd0;
                n_part       = '0;
            end else if (left_e == 2'd1) begin
                o_res_valid      = 1'b1;
                o_res.code_point = part_sh;
                o_res.last       = (cnt_inc == lim_e);
                n_cnt            = cnt_inc;
                n_active         = !(cnt_inc == lim_e);
                n_left           = 2'd0;
                n_part           = '0;
            end else begin
                n_left = left_e - 2'd1;
                n_part = part_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= 2'd0;
            r_part   <= '0;
            r_cnt    <= '0;
            r_lim    <= '0;
        end else if (fire) begin
            r_active <= n_active;
            r_left   <= n_left;
            r_part   <= n_part;
            r_cnt    <= n_cnt;
            r_lim    <= n_lim;
        end
    end

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_res_valid && o_res.last |=> !r_active)
        else $error("string still active after its last result");

    a_idle_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_left == 2'd0))
        else $error("sequence pending while idle");

    a_count_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt < r_lim))
        else $error("character count reached limit while active");

    a_end_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_res_valid && (o_res.status != u8d_pkg::ST_CHAR)
        |-> (o_res.code_point == '0) && o_res.last)
        else $error("terminator or error with payload or without last");

endmodule

// ===== rtl/u8d_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8d_out_reg
// result register stage, holds one result until the downstream transfer
// ----------------------------------------------------------------------------
module u8d_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_res_valid,
    input  u8d_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output u8d_pkg::t_result o_res
);

    logic             r_valid;
    u8d_pkg::t_result r_res;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/utf8_to_utf32_decoder.sv =====
// the byte that completes a result is held in the input register, decoded combinationally, and
// its result is registered in the result register; a stalled output can hold either register
// throughput: one byte per cycle while the output is not stalled, zero or one result per byte
// an input register and a result register part the sides, so a stalled result blocks input
// only once both registers are full
// reset: synchronous active-low i_rst_n clears both stages and the decode state (idle)
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// streaming utf-8 byte decoder producing 21-bit code points with status
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder #(
    parameter int COUNT_BITS = u8d_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [u8d_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte, char_limit
    input  logic                              s_axis_tuser,  // start_of_string
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [u8d_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // code_point, zero pad
    output logic [1:0]                        m_axis_tuser,  // status
    output logic                              m_axis_tlast
);

    u8d_pkg::t_in_item in_item;
    u8d_pkg::t_in_item q_item;
    u8d_pkg::t_result  res;
    u8d_pkg::t_result  out_res;
    logic              q_valid;
    logic              advance;
    logic              res_valid;

    assign in_item.data_byte       = s_axis_tdata[7:0];
    assign in_item.char_limit      = s_axis_tdata[23:8];
    assign in_item.start_of_string = s_axis_tuser;

    u8d_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    u8d_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_advance   (advance),
        .i_item      (q_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    u8d_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (q_valid),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_advance   (advance),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {{(u8d_pkg::OUT_TDATA_W-u8d_pkg::CODE_W){1'b0}}, out_res.code_point};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 to utf-32 decoder: directed strings, then
// random strings with noise, a decode model predicting every output transfer,
// random idling and stalls on both stream sides
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTE_TARGET = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP = 40;
    localparam int CNT_W = u8d_pkg::COUNT_BITS_DEF;

    typedef struct packed {
        logic              hold;
        u8d_pkg::t_in_item item;
    } t_byte_xfer;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [u8d_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // data_byte, char_limit
    logic                            s_axis_tuser = 1'b0; // start_of_string
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [u8d_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // code_point, zero pad
    logic [1:0]                      m_axis_tuser;        // status
    logic                            m_axis_tlast;

    t_byte_xfer          pending_bytes[$];
    u8d_pkg::t_result    expected_codes[$];
    int unsigned         error_count = 0;
    int unsigned         cycle_count = 0;

    // decode model state
    logic                        dec_active = 1'b0;
    logic [1:0]                  dec_left = '0;
    logic [u8d_pkg::CODE_W-1:0]  dec_code = '0;
    logic [CNT_W-1:0]            dec_count = '0;
    logic [CNT_W-1:0]            dec_limit = '0;

    // stimulus staging
    logic                        staged_start = 1'b0;
    logic [u8d_pkg::LIMIT_W-1:0] staged_limit = '0;
    logic                        staged_hold = 1'b0;

    u8d_pkg::t_in_item cur_item;
    int unsigned       send_gap = 0;
    int unsigned       send_calm = 0;
    int unsigned       stall_left = 0;
    int unsigned       recv_calm = 0;

    utf8_to_utf32_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    task automatic decode_byte(input u8d_pkg::t_in_item it);
        logic [7:0]       b;
        u8d_pkg::t_result r;
        bit               hit;
        b = it.data_byte;
        r = '0;
        hit = 0;
        if (it.start_of_string) begin
            dec_active = 1'b1;
            dec_count = '0;
            dec_limit = CNT_W'(it.char_limit);
            dec_left = '0;
            dec_code = '0;
            if (dec_limit == '0) dec_active = 1'b0;
        end
        if (dec_active) begin
            if (dec_left == 2'd0) begin
                if (b == 8'h00) begin
                    r.status = u8d_pkg::ST_TERM;
                    r.last = 1'b1;
                    hit = 1;
                end else if (b < 8'h80) begin
                    dec_count++;
                    r.code_point = u8d_pkg::CODE_W'(b & u8d_pkg::ASCII_MASK);
                    r.status = u8d_pkg::ST_CHAR;
                    r.last = (dec_count == dec_limit);
                    hit = 1;
                end else if (b < 8'hC0 || b >= 8'hF8) begin
                    r.status = u8d_pkg::ST_BAD_LEAD;
                    r.last = 1'b1;
                    hit = 1;
                end else if (b < 8'hE0) begin
                    dec_left = 2'd1;
                    dec_code = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD2_MASK);
                end else if (b < 8'hF0) begin
                    dec_left = 2'd2;
                    dec_code = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD3_MASK);
                end else begin
                    dec_left = 2'd3;
                    dec_code = u8d_pkg::CODE_W'(b & u8d_pkg::LEAD4_MASK);
                end
            end else if ((b & u8d_pkg::CONT_TAG_SEL) != u8d_pkg::CONT_TAG) begin
                dec_left = '0;
                dec_code = '0;
                r.status = u8d_pkg::ST_BAD_CONT;
                r.last = 1'b1;
                hit = 1;
            end else begin
                dec_code = {dec_code[u8d_pkg::CODE_W-7:0], b[5:0]};
                dec_left = dec_left - 2'd1;
                if (dec_left == 2'd0) begin
                    dec_count++;
                    r.code_point = dec_code;
                    r.status = u8d_pkg::ST_CHAR;
                    r.last = (dec_count == dec_limit);
                    hit = 1;
                    dec_code = '0;
                end
            end
        end
        if (hit) begin
            if (r.last) dec_active = 1'b0;
            expected_codes.push_back(r);
        end
    endtask

    task automatic open_string(input logic [u8d_pkg::LIMIT_W-1:0] lim, input logic hold);
        staged_start = 1'b1;
        staged_limit = lim;
        staged_hold = hold;
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_byte_xfer x;
        x.hold = staged_hold;
        x.item.data_byte = b;
        x.item.start_of_string = staged_start;
        x.item.char_limit = staged_start ? staged_limit
                                         : u8d_pkg::LIMIT_W'($urandom_range(0, 65535));
        pending_bytes.push_back(x);
        staged_start = 1'b0;
        staged_hold = 1'b0;
    endtask

    task automatic push_random_char();
        int unsigned n;
        n = $urandom_range(1, 4);
        case (n)
            1: begin
                push_byte(8'($urandom_range(1, 127)));
            end
            2: begin
                push_byte(8'hC0 | 8'($urandom_range(0, 31)));
            end
            3: begin
                push_byte(8'hE0 | 8'($urandom_range(0, 15)));
            end
            default: begin
                push_byte(8'hF0 | 8'($urandom_range(0, 7)));
            end
        endcase
        repeat (n - 1) push_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // stimulus and end of run
    initial begin
        int unsigned r;
        int unsigned nchars;
        logic [u8d_pkg::LIMIT_W-1:0] lim;

        open_string(16'h0000, 1'b0);
        push_byte(8'h41);
        push_byte(8'h42);
        open_string(16'hFFFF, 1'b0);
        push_byte(8'h00);
        open_string(16'hFFFF, 1'b0);
        push_byte(8'h7F);
        push_byte(8'hC2);
        push_byte(8'h80);
        push_byte(8'hDF);
        push_byte(8'hBF);
        push_byte(8'hEF);
        push_byte(8'hBF);
        push_byte(8'hBF);
        push_byte(8'hF7);
        push_byte(8'hBF);
        push_byte(8'hBF);
        push_byte(8'hBF);
        push_byte(8'h80);
        push_byte(8'h41);
        open_string(16'hFFFF, 1'b1);
        push_byte(8'hF8);
        open_string(16'h8000, 1'b0);
        push_byte(8'hFF);
        open_string(16'h00FF, 1'b0);
        push_byte(8'hE2);
        push_byte(8'h41);
        open_string(16'h0100, 1'b0);
        push_byte(8'hC3);
        push_byte(8'h00);
        open_string(16'h0002, 1'b0);
        push_byte(8'hF0);
        open_string(16'h0002, 1'b1);
        push_byte(8'h41);
        push_byte(8'h42);
        push_byte(8'h43);
        open_string(16'h0001, 1'b0);
        push_byte(8'hC3);
        push_byte(8'hA9);
        open_string(16'h7FFF, 1'b0);
        push_byte(8'hF0);
        push_byte(8'hC0);

        while (pending_bytes.size() < BYTE_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 5) lim = '0;
            else if (r < 75) lim = u8d_pkg::LIMIT_W'($urandom_range(1, 8));
            else if (r < 90) lim = u8d_pkg::LIMIT_W'($urandom_range(9, 40));
            else lim = u8d_pkg::LIMIT_W'($urandom_range(0, 65535));
            open_string(lim, $urandom_range(0, 24) == 0);
            nchars = $urandom_range(0, 10);
            repeat (nchars) push_random_char();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                push_byte(8'h00);
            end else if (r < 55) begin
                push_byte(8'($urandom_range(0, 255)));
            end else if (r < 65) begin
                push_byte(8'hC0 | 8'($urandom_range(0, 55)));
                push_byte(8'($urandom_range(0, 255)));
            end else if (r < 72) begin
                if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(8'h80, 8'hBF)));
                else push_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end else if (r < 80) begin
                push_byte(8'hE0 | 8'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(cur_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes[0].hold && expected_codes.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cur_item = pending_bytes.pop_front().item;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_item.char_limit, cur_item.data_byte};
                    s_axis_tuser <= cur_item.start_of_string;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = random_gap();
                        if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
                    end
                end
            end
        end
    end

    // code point monitor
    always @(posedge i_clk) begin
        u8d_pkg::t_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer tdata=%h tuser=%0d tlast=%0b",
                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end else begin
                    exp_r = expected_codes.pop_front();
                    if (m_axis_tdata !== {{(u8d_pkg::OUT_TDATA_W-u8d_pkg::CODE_W){1'b0}},
                                          exp_r.code_point})
                        report_mismatch($sformatf("code point %h, expected %h",
                            m_axis_tdata, exp_r.code_point));
                    if (m_axis_tuser !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            m_axis_tuser, exp_r.status));
                    if (m_axis_tlast !== exp_r.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                            m_axis_tlast, exp_r.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else begin
                    stall_left = random_gap();
                    if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== utf8_to_utf32_decoder.f =====
rtl/u8d_pkg.sv
rtl/u8d_in_reg.sv
rtl/u8d_core.sv
rtl/u8d_out_reg.sv
rtl/utf8_to_utf32_decoder.sv
verif/tb_top.sv
